### sv/hbeg_pkg.sv
// ----------------------------------------------------------------------------
// hbeg_pkg
// shared widths, constants and sideband types of the bond energy/gradient core
// ----------------------------------------------------------------------------
package hbeg_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 32;
    localparam int MAG_W       = 32;          // |p1 - p2| on raw values
    localparam int RAD_W       = 70;          // sum of squares, padded to even
    localparam int ROOT_W      = RAD_W / 2;   // distance d
    localparam int SQ_REM_W    = ROOT_W + 2;
    localparam int NUM_W       = 100;         // k * |d - r0| * |p1 - p2|
    localparam int QUO_W       = 51;          // quotient bound k*|d-r0| / 2^F
    localparam int DVS_W       = ROOT_W + FRAC_BITS;
    localparam int ENERGY_W    = 63;
    localparam int GRAD_W      = 48;
    localparam int KDIV_W      = 26;
    localparam int LANES       = 3;

    localparam logic [30:0] DIV100_MAGIC = 31'h51EB851F;
    localparam int          DIV100_SHIFT = 37;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [GRAD_W-1:0]   GRAD_LIM   = {1'b1, {(GRAD_W-1){1'b0}}};

    // sideband carried through the square root
    typedef struct packed {
        logic [15:0]                   first_atom;
        logic [15:0]                   second_atom;
        logic [31:0]                   rest_length;
        logic [31:0]                   force_constant;
        logic [KDIV_W-1:0]             kdiv;
        logic [LANES-1:0][MAG_W-1:0]   mag;
        logic [LANES-1:0]              diff_neg;
    } t_side_a;

    // sideband carried through the dividers
    typedef struct packed {
        logic [15:0]          first_atom;
        logic [15:0]          second_atom;
        logic [ENERGY_W-1:0]  energy;
        logic [LANES-1:0]     neg;
        logic                 zero;
        logic [KDIV_W-1:0]    kdiv;
    } t_side_b;

endpackage

### sv/hbeg_sqrt.sv
// ----------------------------------------------------------------------------
// hbeg_sqrt
// pipelined digit-by-digit integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module hbeg_sqrt (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [hbeg_pkg::RAD_W-1:0]            i_rad,
    input  hbeg_pkg::t_side_a                     i_side,
    output logic                                  o_valid,
    output logic [hbeg_pkg::ROOT_W-1:0]           o_root,
    output hbeg_pkg::t_side_a                     o_side
);

    localparam int N = hbeg_pkg::ROOT_W;
    localparam int RW = hbeg_pkg::SQ_REM_W;

    logic                              r_val  [N];
    logic [hbeg_pkg::RAD_W-1:0]        r_rad  [N];
    logic [RW-1:0]                     r_rem  [N];
    logic [N-1:0]                      r_root [N];
    hbeg_pkg::t_side_a                 r_side [N];

    logic                              p_val  [N];
    logic [hbeg_pkg::RAD_W-1:0]        p_rad  [N];
    logic [RW-1:0]                     p_rem  [N];
    logic [N-1:0]                      p_root [N];
    hbeg_pkg::t_side_a                 p_side [N];

    logic [hbeg_pkg::RAD_W-1:0]        n_rad  [N];
    logic [RW-1:0]                     n_rem  [N];
    logic [N-1:0]                      n_root [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_link
            if (g == 0) begin : g_first
                assign p_val[g]  = i_valid;
                assign p_rad[g]  = i_rad;
                assign p_rem[g]  = '0;
                assign p_root[g] = '0;
                assign p_side[g] = i_side;
            end else begin : g_next
                assign p_val[g]  = r_val[g-1];
                assign p_rad[g]  = r_rad[g-1];
                assign p_rem[g]  = r_rem[g-1];
                assign p_root[g] = r_root[g-1];
                assign p_side[g] = r_side[g-1];
            end
        end
    endgenerate

    // bring down two radicand bits, try (root << 2) | 1
    always_comb begin
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        for (int j = 0; j < N; j++) begin
            t     = {p_rem[j], p_rad[j][hbeg_pkg::RAD_W-1 -: 2]};
            trial = {1'b0, p_root[j], 2'b01};
            if (t >= trial) begin
                n_rem[j]  = RW'(t - trial);
                n_root[j] = {p_root[j][N-2:0], 1'b1};
            end else begin
                n_rem[j]  = RW'(t);
                n_root[j] = {p_root[j][N-2:0], 1'b0};
            end
            n_rad[j] = {p_rad[j][hbeg_pkg::RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) r_val[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < N; j++) r_val[j] <= p_val[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N; j++) begin
                r_rad[j]  <= n_rad[j];
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_side[j] <= p_side[j];
            end
        end
    end

    assign o_valid = r_val[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

### sv/hbeg_div.sv
// ----------------------------------------------------------------------------
// hbeg_div
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module hbeg_div (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_en,
    input  logic                                              i_valid,
    input  logic [hbeg_pkg::LANES-1:0][hbeg_pkg::NUM_W-1:0]   i_num,
    input  logic [hbeg_pkg::DVS_W-1:0]                        i_dvs,
    input  hbeg_pkg::t_side_b                                 i_side,
    output logic                                              o_valid,
    output logic [hbeg_pkg::LANES-1:0][hbeg_pkg::QUO_W-1:0]   o_quo,
    output hbeg_pkg::t_side_b                                 o_side
);

    localparam int N  = hbeg_pkg::QUO_W;
    localparam int L  = hbeg_pkg::LANES;
    localparam int XW = 2 * N;   // remainder on top, numerator/quotient below

    logic                              r_val  [N];
    logic [L-1:0][XW-1:0]              r_x    [N];
    logic [hbeg_pkg::DVS_W-1:0]        r_dvs  [N];
    hbeg_pkg::t_side_b                 r_side [N];

    logic                              p_val  [N];
    logic [L-1:0][XW-1:0]              p_x    [N];
    logic [hbeg_pkg::DVS_W-1:0]        p_dvs  [N];
    hbeg_pkg::t_side_b                 p_side [N];

    logic [L-1:0][XW-1:0]              n_x    [N];

    genvar g, h;
    generate
        for (g = 0; g < N; g++) begin : g_link
            if (g == 0) begin : g_first
                assign p_val[g]  = i_valid;
                for (h = 0; h < L; h++) begin : g_lane
                    assign p_x[g][h] = XW'(i_num[h]);
                end
                assign p_dvs[g]  = i_dvs;
                assign p_side[g] = i_side;
            end else begin : g_next
                assign p_val[g]  = r_val[g-1];
                assign p_x[g]    = r_x[g-1];
                assign p_dvs[g]  = r_dvs[g-1];
                assign p_side[g] = r_side[g-1];
            end
        end
    endgenerate

    always_comb begin
        logic [N:0] t;
        for (int j = 0; j < N; j++) begin
            for (int l = 0; l < L; l++) begin
                t = p_x[j][l][XW-1:N-1];
                if (t >= {1'b0, p_dvs[j]}) begin
                    n_x[j][l] = {N'(t - {1'b0, p_dvs[j]}), p_x[j][l][N-2:0], 1'b1};
                end else begin
                    n_x[j][l] = {t[N-1:0], p_x[j][l][N-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) r_val[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < N; j++) r_val[j] <= p_val[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N; j++) begin
                r_x[j]    <= n_x[j];
                r_dvs[j]  <= p_dvs[j];
                r_side[j] <= p_side[j];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < L; l++) o_quo[l] = r_x[N-1][l][N-1:0];
    end
    assign o_valid = r_val[N-1];
    assign o_side  = r_side[N-1];

endmodule

### sv/harmonic_bond_energy_gradient_core.sv
// ----------------------------------------------------------------------------
// harmonic_bond_energy_gradient_core
// harmonic bond stretch energy and first-atom gradient, unless stalled one bond per cycle
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  bond in  | i_valid / o_stall   | atom indices, xyz of both atoms, r0, k
//  result   | o_valid / i_stall   | atom indices, energy, grad x/y/z
//
//  one bond enters every cycle while o_stall is low; the path includes
//  35 square root stages, 51 divider stages and one output register
//  reset is synchronous, active low, and clears every valid bit
//  the whole pipeline holds while a result waits under i_stall; bubbles
//  advance freely otherwise, so no item is lost or repeated
//
module harmonic_bond_energy_gradient_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [15:0]                           i_first_atom,
    input  logic [15:0]                           i_second_atom,
    input  logic signed [31:0]                    i_first_x,
    input  logic signed [31:0]                    i_first_y,
    input  logic signed [31:0]                    i_first_z,
    input  logic signed [31:0]                    i_second_x,
    input  logic signed [31:0]                    i_second_y,
    input  logic signed [31:0]                    i_second_z,
    input  logic [31:0]                           i_rest_length,
    input  logic [31:0]                           i_force_constant,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [15:0]                           o_first_atom_out,
    output logic [15:0]                           o_second_atom_out,
    output logic [hbeg_pkg::ENERGY_W-1:0]         o_bond_energy,
    output logic signed [hbeg_pkg::GRAD_W-1:0]    o_grad_x,
    output logic signed [hbeg_pkg::GRAD_W-1:0]    o_grad_y,
    output logic signed [hbeg_pkg::GRAD_W-1:0]    o_grad_z
);

    localparam int L = hbeg_pkg::LANES;

    // global advance: everything moves unless a finished item is held
    logic w_en;
    logic r_out_val;
    assign w_en    = !(r_out_val && i_stall);
    assign o_stall = !w_en;

    // ---- stage 1: coordinate differences, k/100 by reciprocal
    logic                            r1_val;
    logic [L-1:0][32:0]              r1_diff;
    logic [15:0]                     r1_fa, r1_sa;
    logic [31:0]                     r1_r0, r1_k;
    logic [hbeg_pkg::KDIV_W-1:0]     r1_kdiv;
    logic [L-1:0][32:0]              n1_diff;
    logic [62:0]                     n1_kprod;

    always_comb begin
        n1_diff[0] = 33'({i_first_x[31], i_first_x} - {i_second_x[31], i_second_x});
        n1_diff[1] = 33'({i_first_y[31], i_first_y} - {i_second_y[31], i_second_y});
        n1_diff[2] = 33'({i_first_z[31], i_first_z} - {i_second_z[31], i_second_z});
        n1_kprod   = i_force_constant * hbeg_pkg::DIV100_MAGIC;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_diff <= n1_diff;
            r1_fa   <= i_first_atom;
            r1_sa   <= i_second_atom;
            r1_r0   <= i_rest_length;
            r1_k    <= i_force_constant;
            r1_kdiv <= n1_kprod[hbeg_pkg::DIV100_SHIFT +: hbeg_pkg::KDIV_W];
        end
    end

    // ---- stage 2: magnitudes and squares
    logic                            r2_val;
    logic [L-1:0][63:0]              r2_sq;
    hbeg_pkg::t_side_a               r2_side;
    logic [L-1:0][31:0]              n2_mag;

    always_comb begin
        for (int l = 0; l < L; l++) begin
            n2_mag[l] = r1_diff[l][32] ? 32'(-r1_diff[l]) : r1_diff[l][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < L; l++) begin
                r2_sq[l]            <= n2_mag[l] * n2_mag[l];
                r2_side.mag[l]      <= n2_mag[l];
                r2_side.diff_neg[l] <= r1_diff[l][32];
            end
            r2_side.first_atom     <= r1_fa;
            r2_side.second_atom    <= r1_sa;
            r2_side.rest_length    <= r1_r0;
            r2_side.force_constant <= r1_k;
            r2_side.kdiv           <= r1_kdiv;
        end
    end

    // ---- stage 3: sum of squares
    logic                            r3_val;
    logic [hbeg_pkg::RAD_W-1:0]      r3_sum;
    hbeg_pkg::t_side_a               r3_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sum  <= hbeg_pkg::RAD_W'(r2_sq[0]) + hbeg_pkg::RAD_W'(r2_sq[1])
                     + hbeg_pkg::RAD_W'(r2_sq[2]);
            r3_side <= r2_side;
        end
    end

    // ---- distance
    logic                            w_sq_val;
    logic [hbeg_pkg::ROOT_W-1:0]     w_d;
    hbeg_pkg::t_side_a               w_sq_side;

    hbeg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_val),
        .i_rad   (r3_sum),
        .i_side  (r3_side),
        .o_valid (w_sq_val),
        .o_root  (w_d),
        .o_side  (w_sq_side)
    );

    // ---- stage 4: d - r0 and its magnitude
    logic                            r4_val;
    logic [hbeg_pkg::ROOT_W-1:0]     r4_dm, r4_d;
    logic [31:0]                     r4_k, r4_r0;
    logic [L-1:0][31:0]              r4_mag;
    hbeg_pkg::t_side_b               r4_side;
    logic [hbeg_pkg::ROOT_W:0]       n4_delta;

    assign n4_delta = {1'b0, w_d} - (hbeg_pkg::ROOT_W+1)'(w_sq_side.rest_length);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_dm  <= n4_delta[hbeg_pkg::ROOT_W] ?
                      hbeg_pkg::ROOT_W'(-n4_delta) : n4_delta[hbeg_pkg::ROOT_W-1:0];
            r4_d   <= w_d;
            r4_k   <= w_sq_side.force_constant;
            r4_r0  <= w_sq_side.rest_length;
            r4_mag <= w_sq_side.mag;
            r4_side.first_atom  <= w_sq_side.first_atom;
            r4_side.second_atom <= w_sq_side.second_atom;
            r4_side.energy      <= '0;
            r4_side.neg  <= w_sq_side.diff_neg ^ {L{n4_delta[hbeg_pkg::ROOT_W]}};
            r4_side.zero <= (w_d == '0);
            r4_side.kdiv <= w_sq_side.kdiv;
        end
    end

    // ---- stage 5: dm^2 and k*dm
    logic                            r5_val;
    logic [69:0]                     r5_dm2;
    logic [66:0]                     r5_km;
    logic [31:0]                     r5_k;
    logic [L-1:0][31:0]              r5_mag;
    logic [hbeg_pkg::ROOT_W-1:0]     r5_d;
    hbeg_pkg::t_side_b               r5_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_dm2  <= r4_dm * r4_dm;
            r5_km   <= r4_k * r4_dm;
            r5_k    <= r4_k;
            r5_mag  <= r4_mag;
            r5_d    <= r4_d;
            r5_side <= r4_side;
        end
    end

    // ---- stage 6: partial products of energy and numerators
    logic                            r6_val;
    logic [66:0]                     r6_ea, r6_eb;
    logic [L-1:0][65:0]              r6_na;
    logic [L-1:0][64:0]              r6_nb;
    logic [hbeg_pkg::ROOT_W-1:0]     r6_d;
    hbeg_pkg::t_side_b               r6_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_ea <= r5_dm2[34:0] * r5_k;
            r6_eb <= r5_dm2[69:35] * r5_k;
            for (int l = 0; l < L; l++) begin
                r6_na[l] <= r5_km[33:0] * r5_mag[l];
                r6_nb[l] <= r5_km[66:34] * r5_mag[l];
            end
            r6_d    <= r5_d;
            r6_side <= r5_side;
        end
    end

    // ---- stage 7: assemble, energy saturation
    logic                                          r7_val;
    logic [L-1:0][hbeg_pkg::NUM_W-1:0]             r7_num;
    logic [hbeg_pkg::DVS_W-1:0]                    r7_dvs;
    hbeg_pkg::t_side_b                             r7_side;
    logic [101:0]                                  n7_e;

    assign n7_e = 102'(r6_ea) + {r6_eb, 35'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < L; l++) begin
                r7_num[l] <= hbeg_pkg::NUM_W'(r6_na[l]) + {r6_nb[l][65-1:0], 34'd0}
                             + hbeg_pkg::NUM_W'(0);
            end
            r7_dvs  <= {r6_d, hbeg_pkg::FRAC_BITS'(0)};
            r7_side.first_atom  <= r6_side.first_atom;
            r7_side.second_atom <= r6_side.second_atom;
            r7_side.neg         <= r6_side.neg;
            r7_side.zero        <= r6_side.zero;
            r7_side.kdiv        <= r6_side.kdiv;
            // e >> (2F+1), saturating to 63 bits
            r7_side.energy <= (|n7_e[101:96]) ? hbeg_pkg::ENERGY_MAX : n7_e[95:33];
        end
    end

    // ---- gradient quotients
    logic                                          w_dv_val;
    logic [L-1:0][hbeg_pkg::QUO_W-1:0]             w_quo;
    hbeg_pkg::t_side_b                             w_dv_side;

    hbeg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_val),
        .i_num   (r7_num),
        .i_dvs   (r7_dvs),
        .i_side  (r7_side),
        .o_valid (w_dv_val),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // ---- output register: saturate and apply sign, coincident atoms case
    logic [L-1:0][hbeg_pkg::GRAD_W-1:0]            r_out_grad;
    logic [15:0]                                   r_out_fa, r_out_sa;
    logic [hbeg_pkg::ENERGY_W-1:0]                 r_out_energy;
    logic                                          r_out_zero;
    logic [L-1:0][hbeg_pkg::GRAD_W-1:0]            n_grad;

    always_comb begin
        logic [hbeg_pkg::GRAD_W-1:0] lim;
        logic [hbeg_pkg::GRAD_W-1:0] m;
        for (int l = 0; l < L; l++) begin
            lim = w_dv_side.neg[l] ? hbeg_pkg::GRAD_LIM : hbeg_pkg::GRAD_LIM - 1'b1;
            m   = (w_quo[l] > hbeg_pkg::QUO_W'(lim)) ? lim : w_quo[l][hbeg_pkg::GRAD_W-1:0];
            if (w_dv_side.zero) begin
                n_grad[l] = hbeg_pkg::GRAD_W'(w_dv_side.kdiv);
            end else if (w_dv_side.neg[l]) begin
                n_grad[l] = -m;
            end else begin
                n_grad[l] = m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_grad   <= n_grad;
            r_out_fa     <= w_dv_side.first_atom;
            r_out_sa     <= w_dv_side.second_atom;
            r_out_energy <= w_dv_side.energy;
            r_out_zero   <= w_dv_side.zero;
        end
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_val    <= 1'b0;
            r2_val    <= 1'b0;
            r3_val    <= 1'b0;
            r4_val    <= 1'b0;
            r5_val    <= 1'b0;
            r6_val    <= 1'b0;
            r7_val    <= 1'b0;
            r_out_val <= 1'b0;
        end else if (w_en) begin
            r1_val    <= i_valid;
            r2_val    <= r1_val;
            r3_val    <= r2_val;
            r4_val    <= w_sq_val;
            r5_val    <= r4_val;
            r6_val    <= r5_val;
            r7_val    <= r6_val;
            r_out_val <= w_dv_val;
        end
    end

    assign o_valid           = r_out_val;
    assign o_first_atom_out  = r_out_fa;
    assign o_second_atom_out = r_out_sa;
    assign o_bond_energy     = r_out_energy;
    assign o_grad_x          = r_out_grad[0];
    assign o_grad_y          = r_out_grad[1];
    assign o_grad_z          = r_out_grad[2];

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // coincident atoms: |d - r0| is the rest length
    a_zero_dm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_val && r4_side.zero) |-> (r4_dm == hbeg_pkg::ROOT_W'(r4_r0)))
        else $error("distance offset wrong for coincident atoms");

    // coincident atoms give three equal gradient components
    a_zero_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_zero) |-> (o_grad_x == o_grad_y && o_grad_y == o_grad_z))
        else $error("unequal gradient for coincident atoms");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// streams bonds through the energy/gradient core under random idling and
// checks every result against an in-bench predictor of energy and gradient
// ----------------------------------------------------------------------------

// one expected result
typedef struct {
    logic [15:0]                        first_atom;
    logic [15:0]                        second_atom;
    logic [hbeg_pkg::ENERGY_W-1:0]      energy;
    logic [hbeg_pkg::GRAD_W-1:0]        grad [3];
} t_bond_result;

class bond_scoreboard;
    t_bond_result pending[$];
    int           mismatches;

    // predicts the result of one accepted bond
    function void note_bond(logic [15:0] a1, logic [15:0] a2,
                            logic signed [31:0] p1 [3], logic signed [31:0] p2 [3],
                            logic [31:0] r0, logic [31:0] k);
        t_bond_result r;
        logic signed [33:0] diff [3];
        logic [33:0]        mag [3];
        logic [69:0]        sum;
        logic [69:0]        t;
        logic [34:0]        d;
        logic [35:0]        dm;
        logic               dneg;
        logic [199:0]       wide_e;
        logic [199:0]       num;
        logic [199:0]       q;
        logic               neg;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            diff[i] = 34'(p1[i]) - 34'(p2[i]);
            mag[i]  = diff[i] < 0 ? 34'(-diff[i]) : 34'(diff[i]);
            sum     = sum + 70'(mag[i]) * 70'(mag[i]);
        end
        // bitwise integer square root
        d = '0;
        for (int b = 34; b >= 0; b--) begin
            t = 70'(d | (35'd1 << b));
            if (t * t <= sum) d = d | (35'd1 << b);
        end
        dneg = d < 35'(r0);
        dm   = dneg ? 36'(r0) - 36'(d) : 36'(d) - 36'(r0);
        wide_e = (200'(dm) * 200'(dm) * 200'(k)) >> (2 * hbeg_pkg::FRAC_BITS + 1);
        r.first_atom  = a1;
        r.second_atom = a2;
        r.energy = (wide_e > 200'(64'h7FFF_FFFF_FFFF_FFFF)) ? '1 : wide_e[62:0];
        for (int i = 0; i < 3; i++) begin
            if (d == 0) begin
                // coincident atoms: flat k/100 on every component
                r.grad[i] = 48'(k / 100);
            end else begin
                num = 200'(k) * 200'(dm) * 200'(mag[i]);
                q   = num / (200'(d) << hbeg_pkg::FRAC_BITS);
                neg = dneg != (diff[i] < 0);
                if (neg) begin
                    if (q > 200'(48'h8000_0000_0000)) q = 200'(48'h8000_0000_0000);
                    r.grad[i] = -q[47:0];
                end else begin
                    if (q > 200'(48'h7FFF_FFFF_FFFF)) q = 200'(48'h7FFF_FFFF_FFFF);
                    r.grad[i] = q[47:0];
                end
            end
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [15:0] a1, logic [15:0] a2, logic [62:0] en,
                               logic [47:0] gx, logic [47:0] gy, logic [47:0] gz);
        t_bond_result e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result a1=%0d a2=%0d", a1, a2);
            return;
        end
        e = pending.pop_front();
        if (e.first_atom !== a1 || e.second_atom !== a2 || e.energy !== en ||
            e.grad[0] !== gx || e.grad[1] !== gy || e.grad[2] !== gz) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch exp a=%h/%h e=%h g=%h %h %h", e.first_atom,
                         e.second_atom, e.energy, e.grad[0], e.grad[1], e.grad[2]);
                $display("         got a=%h/%h e=%h g=%h %h %h", a1, a2, en, gx, gy, gz);
            end
        end
    endfunction
endclass

module testbench;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic [15:0] i_first_atom = '0, i_second_atom = '0;
    logic signed [31:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic signed [31:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic [31:0] i_rest_length = '0, i_force_constant = '0;
    logic [15:0] o_first_atom_out, o_second_atom_out;
    logic [hbeg_pkg::ENERGY_W-1:0] o_bond_energy;
    logic signed [hbeg_pkg::GRAD_W-1:0] o_grad_x, o_grad_y, o_grad_z;

    bond_scoreboard board = new();
    bit quiet = 1'b0;   // long stretch with no idling on either side

    always #5 i_clk = ~i_clk;

    harmonic_bond_energy_gradient_core dut (.*);

    // note each accepted bond at the edge that takes it
    always @(posedge i_clk) begin
        logic signed [31:0] p1 [3];
        logic signed [31:0] p2 [3];
        if (i_rst_n && i_valid && !o_stall) begin
            p1 = '{i_first_x, i_first_y, i_first_z};
            p2 = '{i_second_x, i_second_y, i_second_z};
            board.note_bond(i_first_atom, i_second_atom, p1, p2,
                            i_rest_length, i_force_constant);
        end
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_first_atom_out, o_second_atom_out, o_bond_energy,
                               o_grad_x, o_grad_y, o_grad_z);
    end

    // receiver stalls at random
    always @(posedge i_clk)
        i_stall <= !quiet && ($urandom_range(99) < 28);

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
            default: return $urandom();
        endcase
    endfunction

    // drives one bond and holds it until accepted
    task automatic send_bond(logic [15:0] a1, logic [15:0] a2,
                             logic [31:0] x1, logic [31:0] y1, logic [31:0] z1,
                             logic [31:0] x2, logic [31:0] y2, logic [31:0] z2,
                             logic [31:0] r0, logic [31:0] k);
        while (!quiet && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_atom <= a1;  i_second_atom <= a2;
        i_first_x <= x1;  i_first_y <= y1;  i_first_z <= z1;
        i_second_x <= x2; i_second_y <= y2; i_second_z <= z2;
        i_rest_length <= r0; i_force_constant <= k;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random_bond();
        logic [31:0] x1, y1, z1;
        x1 = pick_coord(); y1 = pick_coord(); z1 = pick_coord();
        if ($urandom_range(15) == 0)
            // coincident atoms
            send_bond(16'($urandom()), 16'($urandom()), x1, y1, z1, x1, y1, z1,
                      $urandom(), $urandom());
        else if ($urandom_range(1))
            send_bond(16'($urandom()), 16'($urandom()), x1, y1, z1,
                      pick_coord(), pick_coord(), pick_coord(),
                      $urandom_range(5 << 16), $urandom_range(1000 << 16));
        else
            send_bond(16'($urandom()), 16'($urandom()), x1, y1, z1,
                      pick_coord(), pick_coord(), pick_coord(), $urandom(), $urandom());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, coincident atoms, d equal to r0, saturation
        send_bond(16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_bond(16'hFFFF, 16'h0000, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bond(16'h1234, 16'h4321, 5, 5, 5, 5, 5, 5, 32'h1_0000, 32'd12345);
        send_bond(1, 2, 32'h3_0000, 0, 0, 0, 32'h4_0000, 0, 32'h5_0000, 32'h10_0000);
        send_bond(3, 4, 32'h1_0000, 0, 0, 0, 0, 0, 32'h2_0000, 32'h10_0000);
        send_bond(5, 6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32'hFFFF_FFFF);
        send_bond(7, 8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bond(9, 10, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000,
                  32'hFFFF_FFFF, 1);
        send_bond(11, 12, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bond(13, 14, 0, 32'hFFFF_0000, 0, 0, 0, 0, 32'h8000_0000, 32'h1_0000);
        send_bond(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_bond(16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        for (int n = 0; n < 600; n++) begin
            quiet = (n >= 200 && n < 300);
            if (n == 350) begin
                // hold off until the pipeline has drained
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (board.pending.size() != 0) @(posedge i_clk);
            end
            send_random_bond();
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
